// File: rtl/assert_macros.svh
// Assertion macros for the parser RTL.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ADFP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked at the same clock edge.
`define ADFP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/adfp_pkg.sv
// Package for the ASCII decimal to fixed-point parser.
// Holds format constants, character codes, parse phases, the snapshot struct and the fraction weight table.
// No dependencies.
`timescale 1ns / 1ps

package adfp_pkg;

	localparam int FRAC_BITS   = 32;
	localparam int FRAC_DIGITS = 10;
	localparam int VALUE_W     = 64;
	localparam int INT_W       = VALUE_W - FRAC_BITS;
	localparam int FRAC_ACC_W  = 36;
	localparam int FIDX_W      = 5;
	localparam int WEIGHT_W    = 29;
	localparam int COUNT_W     = 12;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [INT_W-1:0]   INT_LIMIT = {1'b1, {(INT_W-1){1'b0}}};
	localparam logic [VALUE_W-1:0] VAL_MAX   = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VAL_MIN   = {1'b1, {(VALUE_W-1){1'b0}}};

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_SIGNED,
		PH_INT,
		PH_FRAC
	} adfp_phase_t;

	// Parse state captured on the terminating character.
	typedef struct packed {
		logic                valid;
		logic [VALUE_W-1:0]  mag;
		logic                negative;
		logic                ovf;
		logic [COUNT_W-1:0]  count;
	} adfp_snap_t;

	// Weight of fraction digit k: round(2^FRAC_BITS / 10^k).
	function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [FIDX_W-1:0] k);
		logic [WEIGHT_W-1:0] w;
		case (k)
			5'd1:    w = WEIGHT_W'(64'd429496730);
			5'd2:    w = WEIGHT_W'(64'd42949673);
			5'd3:    w = WEIGHT_W'(64'd4294967);
			5'd4:    w = WEIGHT_W'(64'd429497);
			5'd5:    w = WEIGHT_W'(64'd42950);
			5'd6:    w = WEIGHT_W'(64'd4295);
			5'd7:    w = WEIGHT_W'(64'd429);
			5'd8:    w = WEIGHT_W'(64'd43);
			5'd9:    w = WEIGHT_W'(64'd4);
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// File: rtl/ascii_decimal_to_fixed_parser_unit.sv
// ASCII decimal to signed Q31.32 parser, one character per transfer.
// A terminator passes through the input register, the snapshot register and the output register.
// Throughput: one character per cycle while no result stalls.
// The pipeline (input register, parse stage, output register) freezes while a result stalls.
// Reset clears all valid bits and returns the parser to idle; payload registers are not reset.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ascii_decimal_to_fixed_parser_unit import adfp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                ch,
	input  logic                      first,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] value,
	output logic [COUNT_W-1:0]        consumed,
	output logic                      overflow
);

	logic       adv;
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       first_s1;
	adfp_snap_t snap_s2;

	// Everything moves unless a finished result is held by the consumer.
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			ch_s1    <= ch;
			first_s1 <= first;
		end
	end

	adfp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.ch_s1    (ch_s1),
		.first_s1 (first_s1),
		.snap_s2  (snap_s2)
	);

	adfp_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.snap_s2   (snap_s2),
		.out_valid (out_valid),
		.value     (value),
		.consumed  (consumed),
		.overflow  (overflow)
	);

	`ADFP_ASSERT_IMPL(a_stall_back, out_valid && out_stall, in_stall, "held result must stall input")
	`ADFP_ASSERT_IMPL(a_sat_value, out_valid && overflow, value == VAL_MAX || value == VAL_MIN, "overflow without saturated value")
	`ADFP_ASSERT_IMPL(a_empty_zero, out_valid && consumed == '0, value == '0 && !overflow, "nothing consumed but nonzero result")

endmodule

// File: rtl/adfp_parse.sv
// Character parse stage: phase machine and accumulators, one character per cycle unless the pipeline is stalled.
// Captures the parse state into a snapshot register on the terminator.
// Depends on adfp_pkg.
`timescale 1ns / 1ps

module adfp_parse import adfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       valid_s1,
	input  logic [7:0] ch_s1,
	input  logic       first_s1,
	output adfp_snap_t snap_s2
);

	typedef enum logic [2:0] {
		EV_NONE,
		EV_BLANK,
		EV_SIGN,
		EV_INT,
		EV_DOT,
		EV_FRAC,
		EV_END
	} ev_t;

	adfp_phase_t phase_q, phase_b, phase_d;
	logic                  neg_q, neg_b, neg_d;
	logic [INT_W-1:0]      int_q, int_b, int_d;
	logic [FRAC_ACC_W-1:0] frac_q, frac_b, frac_d;
	logic [FIDX_W-1:0]     fidx_q, fidx_b, fidx_d, fidx_inc;
	logic [COUNT_W-1:0]    cnt_q, cnt_b, cnt_d;
	logic                  ovf_q, ovf_b, ovf_d;

	ev_t                   ev;
	logic                  is_blank, is_sign, is_digit, is_dot;
	logic [3:0]            digit;
	logic [INT_W+3:0]      int_prod;
	logic [WEIGHT_W+3:0]   frac_term;
	logic [VALUE_W-1:0]    mag;
	logic                  step;

	logic                  snap_valid_s2;
	logic [VALUE_W-1:0]    mag_s2;
	logic                  neg_s2;
	logic                  ovf_s2;
	logic [COUNT_W-1:0]    cnt_s2;

	// A character marked first restarts from a cleared parse.
	always_comb begin
		phase_b = first_s1 ? PH_LEAD : phase_q;
		neg_b   = first_s1 ? 1'b0 : neg_q;
		int_b   = first_s1 ? '0 : int_q;
		frac_b  = first_s1 ? '0 : frac_q;
		fidx_b  = first_s1 ? '0 : fidx_q;
		cnt_b   = first_s1 ? '0 : cnt_q;
		ovf_b   = first_s1 ? 1'b0 : ovf_q;
	end

	assign is_blank = (ch_s1 == CH_SPACE) || (ch_s1 == CH_LF) || (ch_s1 == CH_TAB) ||
	                  (ch_s1 == CH_CR) || (ch_s1 == CH_VT);
	assign is_sign  = (ch_s1 == CH_MINUS) || (ch_s1 == CH_PLUS);
	assign is_digit = (ch_s1 >= CH_ZERO) && (ch_s1 <= CH_NINE);
	assign is_dot   = (ch_s1 == CH_DOT);
	assign digit    = 4'(ch_s1 - CH_ZERO);

	always_comb begin
		if (phase_b == PH_IDLE)
			ev = EV_NONE;
		else if (phase_b == PH_LEAD && is_blank)
			ev = EV_BLANK;
		else if (phase_b == PH_LEAD && is_sign)
			ev = EV_SIGN;
		else if (phase_b != PH_FRAC && is_digit)
			ev = EV_INT;
		else if (phase_b != PH_FRAC && is_dot)
			ev = EV_DOT;
		else if (phase_b == PH_FRAC && is_digit)
			ev = EV_FRAC;
		else
			ev = EV_END;
	end

	// Next phase.
	always_comb begin
		unique case (ev)
			EV_SIGN: phase_d = PH_SIGNED;
			EV_INT:  phase_d = PH_INT;
			EV_DOT:  phase_d = PH_FRAC;
			EV_END:  phase_d = PH_IDLE;
			default: phase_d = phase_b;
		endcase
	end

	// Multiply by ten as two shifts and an add, then add the digit.
	assign int_prod  = {int_b, 3'b000} + {2'b00, int_b, 1'b0} + (INT_W+4)'(digit);
	assign fidx_inc  = FIDX_W'(fidx_b + 1'b1);
	assign frac_term = frac_weight(fidx_inc) * digit;

	// Accumulator and counter updates.
	always_comb begin
		neg_d  = neg_b;
		int_d  = int_b;
		frac_d = frac_b;
		fidx_d = fidx_b;
		ovf_d  = ovf_b;
		cnt_d  = cnt_b;
		unique case (ev)
			EV_SIGN: neg_d = (ch_s1 == CH_MINUS);
			EV_INT: begin
				if (int_prod > (INT_W+4)'(INT_LIMIT)) begin
					int_d = INT_LIMIT;
					ovf_d = 1'b1;
				end else begin
					int_d = INT_W'(int_prod);
				end
			end
			EV_FRAC: begin
				if (fidx_b < FIDX_W'(FRAC_DIGITS)) begin
					fidx_d = fidx_inc;
					frac_d = frac_b + FRAC_ACC_W'(frac_term);
				end
			end
			default: ;
		endcase
		if (ev != EV_NONE && ev != EV_END && cnt_b != COUNT_MAX)
			cnt_d = COUNT_W'(cnt_b + 1'b1);
	end

	assign mag  = {int_b, {FRAC_BITS{1'b0}}} + VALUE_W'(frac_b);
	assign step = adv && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			int_q   <= '0;
			frac_q  <= '0;
			fidx_q  <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			neg_q   <= neg_d;
			int_q   <= int_d;
			frac_q  <= frac_d;
			fidx_q  <= fidx_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			snap_valid_s2 <= 1'b0;
		else if (adv)
			snap_valid_s2 <= valid_s1 && (ev == EV_END);
	end

	always_ff @(posedge clk) begin
		if (step && ev == EV_END) begin
			mag_s2 <= mag;
			neg_s2 <= neg_b;
			ovf_s2 <= ovf_b;
			cnt_s2 <= cnt_b;
		end
	end

	always_comb begin
		snap_s2.valid    = snap_valid_s2;
		snap_s2.mag      = mag_s2;
		snap_s2.negative = neg_s2;
		snap_s2.ovf      = ovf_s2;
		snap_s2.count    = cnt_s2;
	end

endmodule

// File: rtl/adfp_result.sv
// Result stage: range check, saturation and sign application into the output register.
// Depends on adfp_pkg.
`timescale 1ns / 1ps

module adfp_result import adfp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  adfp_snap_t                snap_s2,
	output logic                      out_valid,
	output logic signed [VALUE_W-1:0] value,
	output logic [COUNT_W-1:0]        consumed,
	output logic                      overflow
);

	logic               ovf;
	logic [VALUE_W-1:0] val;
	logic               valid_q;
	logic [VALUE_W-1:0] value_q;
	logic [COUNT_W-1:0] consumed_q;
	logic               overflow_q;

	// Negative numbers may reach exactly 2^63; positive ones stop one below.
	assign ovf = snap_s2.ovf ||
	             (!snap_s2.negative && snap_s2.mag[VALUE_W-1]) ||
	             (snap_s2.negative && snap_s2.mag[VALUE_W-1] && |snap_s2.mag[VALUE_W-2:0]);

	always_comb begin
		if (ovf)
			val = snap_s2.negative ? VAL_MIN : VAL_MAX;
		else if (snap_s2.negative)
			val = VALUE_W'(~snap_s2.mag + 1'b1);
		else
			val = snap_s2.mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv)
			valid_q <= snap_s2.valid;
	end

	always_ff @(posedge clk) begin
		if (adv && snap_s2.valid) begin
			value_q    <= val;
			consumed_q <= snap_s2.count;
			overflow_q <= ovf;
		end
	end

	assign out_valid = valid_q;
	assign value     = value_q;
	assign consumed  = consumed_q;
	assign overflow  = overflow_q;

endmodule
